// ===== hdl/dslt_pkg.sv =====
// Shared types and constants for the descending sorted key table.
package dslt_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT       = 3'd0,
    OP_REMOVE       = 3'd1,
    OP_REMOVE_FIRST = 3'd2,
    OP_SEARCH       = 3'd3,
    OP_CLEAR        = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic                    found;
    logic signed [KEY_W-1:0] head_value;
    logic                    head_valid;
    logic [COUNT_W-1:0]      entry_count;
  } out_item_t;

endpackage

// ===== hdl/descending_sorted_list_table_unit.sv =====
// Insert shifts down from the tail; search and remove scan from the head; remove and
// remove-first then shift entries forward (scan and shift both walk the key memory at one
// entry per cycle), and clear only resets the count. One item at a time: the next item is
// taken once the result is registered, given the one-read/one-write key memory.
// Reset: synchronous, active low; empties the table. Key memory has no reset.
// A finished result waits in the output register while the next item is accepted.
module descending_sorted_list_table_unit #(
  parameter int CAPACITY = dslt_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dslt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dslt_pkg::out_item_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [2:0] {S_IDLE, S_INS, S_SCAN, S_DEL, S_RESP} state_t;

  state_t                            state_r, state_nxt;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [CW-1:0]                     idx_r, idx_nxt;
  logic [dslt_pkg::OP_W-1:0]         op_r, op_nxt;
  logic signed [dslt_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [dslt_pkg::STAT_W-1:0]       status_r, status_nxt;
  logic                              found_r, found_nxt;
  logic signed [dslt_pkg::KEY_W-1:0] head_r, head_nxt;
  logic                              out_valid_r, out_valid_nxt;
  dslt_pkg::out_item_t               out_data_r, out_data_nxt;

  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic signed [dslt_pkg::KEY_W-1:0] wr_data;
  logic [AW-1:0]                     rd_addr;
  logic signed [dslt_pkg::KEY_W-1:0] rd_data_r;

  logic signed [dslt_pkg::KEY_W-1:0] key_mem [CAPACITY];

  // Key memory: one write and one registered read per cycle. The sequencer never uses
  // a read of an entry taken in the cycle it is written, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= key_mem[rd_addr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = key_r;
    rd_addr       = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.operation;
          key_nxt    = in_data.key;
          status_nxt = dslt_pkg::ST_OK;
          found_nxt  = 1'b0;
          state_nxt  = S_RESP;
          unique case (in_data.operation) inside
            dslt_pkg::OP_INSERT: begin
              if (count_r == CAP_CNT) begin
                status_nxt = dslt_pkg::ST_FULL;
              end else begin
                idx_nxt   = count_r;
                rd_addr   = AW'(count_r - CW'(1));
                state_nxt = S_INS;
              end
            end
            dslt_pkg::OP_REMOVE, dslt_pkg::OP_SEARCH: begin
              if (count_r == '0) begin
                status_nxt = dslt_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                rd_addr   = '0;
                state_nxt = S_SCAN;
              end
            end
            dslt_pkg::OP_REMOVE_FIRST: begin
              if (count_r == '0) begin
                status_nxt = dslt_pkg::ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                rd_addr   = AW'(1);
                state_nxt = S_DEL;
              end
            end
            dslt_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Walk down from the tail, moving each smaller key one place back.
      S_INS: begin
        if (idx_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = key_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end else if (rd_data_r < key_r) begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx_r);
          wr_data = rd_data_r;
          rd_addr = AW'(idx_r - CW'(2));
          idx_nxt = idx_r - CW'(1);
        end else begin
          wr_en     = 1'b1;
          wr_addr   = AW'(idx_r);
          wr_data   = key_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end
      end

      // rd_data_r holds entry idx_r; prefetch the next one each cycle.
      S_SCAN: begin
        if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          if (op_r == dslt_pkg::OP_REMOVE) begin
            rd_addr   = AW'(idx_r + CW'(1));
            state_nxt = S_DEL;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (idx_r + CW'(1) == count_r) begin
          status_nxt = dslt_pkg::ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end else begin
          idx_nxt = idx_r + CW'(1);
          rd_addr = AW'(idx_r + CW'(1));
        end
      end

      // rd_data_r holds entry idx_r+1; pull it forward into idx_r.
      S_DEL: begin
        if (idx_r + CW'(1) < count_r) begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx_r);
          wr_data = rd_data_r;
          rd_addr = AW'(idx_r + CW'(2));
          idx_nxt = idx_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.found       = found_r;
          out_data_nxt.head_valid  = (count_r != '0);
          out_data_nxt.head_value  = (count_r != '0) ? head_r : '0;
          out_data_nxt.entry_count = dslt_pkg::COUNT_W'(count_r);
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Mirror the first entry so the head needs no extra memory read.
    if (wr_en && wr_addr == '0) begin
      head_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      op_r        <= '0;
      key_r       <= '0;
      status_r    <= '0;
      found_r     <= 1'b0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      op_r        <= op_nxt;
      key_r       <= key_nxt;
      status_r    <= status_nxt;
      found_r     <= found_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("stored count above capacity");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken before first completed");

  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.head_valid == (out_data.entry_count != '0)))
    else $error("head valid disagrees with entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS && idx_r == '0) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the table");
`endif

endmodule
